// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by priority_queue_sorted_unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define PQS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising edge, reset included
`define PQS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/pqs_pkg.sv
// ----------------------------------------------------------------------------
// pqs_pkg
// Shared widths, operation and status codes, and the cell control bundle
// of the sorted priority queue.
// ----------------------------------------------------------------------------
package pqs_pkg;

  localparam int ID_W     = 16;
  localparam int PRI_W    = 8;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int DEPTH_DEF = 16;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_APPEND  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DEQUEUE = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // broadcast to every cell in the row
  typedef struct packed {
    logic             ins;     // place a new entry
    logic             by_pri;  // placement by priority, else at the tail
    logic             deq;     // remove the head, everything moves left
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } pqs_ctrl_t;

endpackage

// File: rtl/pqs_cell.sv
// ----------------------------------------------------------------------------
// pqs_cell
// One slot of the queue row. Decides locally whether the new entry lands
// here, and takes data from its left or right neighbor on insert or dequeue.
// ----------------------------------------------------------------------------
module pqs_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  pqs_pkg::pqs_ctrl_t       ctrl,
  input  logic                     found_in,
  input  logic [pqs_pkg::ID_W-1:0]  left_id,
  input  logic [pqs_pkg::PRI_W-1:0] left_pri,
  input  logic                     left_occ,
  input  logic [pqs_pkg::ID_W-1:0]  right_id,
  input  logic [pqs_pkg::PRI_W-1:0] right_pri,
  input  logic                     right_occ,
  output logic                     found_out,
  output logic [pqs_pkg::ID_W-1:0]  id,
  output logic [pqs_pkg::PRI_W-1:0] pri,
  output logic                     occ
);
  import pqs_pkg::*;

  logic flag;

  // this slot is a legal landing place for the new entry
  assign flag = ctrl.by_pri ? (!occ || (pri <= ctrl.pri)) : !occ;
  assign found_out = found_in | flag;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctrl.ins) begin
      if (found_in) begin
        occ <= left_occ;
      end else if (flag) begin
        occ <= 1'b1;
      end
    end else if (ctrl.deq) begin
      occ <= right_occ;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (found_in) begin
        id  <= left_id;
        pri <= left_pri;
      end else if (flag) begin
        id  <= ctrl.id;
        pri <= ctrl.pri;
      end
    end else if (ctrl.deq) begin
      id  <= right_id;
      pri <= right_pri;
    end
  end

endmodule

// File: rtl/priority_queue_sorted_unit.sv
// the result beat is registered in the cycle after the input beat is accepted
// throughput: one operation per cycle while in_stall is low; every cell of the row updates in parallel
// the insert position comes from a prefix chain of per-cell compares
// reset clears the fill count, all cell occupancy bits and the output valid flag
// entry payloads are not reset; no clearing pass is needed
// ----------------------------------------------------------------------------
// priority_queue_sorted_unit
// Bounded ordered queue of (id, priority) entries built as a row of shifting
// cells: append at tail, insert by priority, dequeue from the head.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module priority_queue_sorted_unit #(
  parameter int DEPTH = pqs_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [pqs_pkg::MODE_W-1:0]   mode,
  input  logic [pqs_pkg::ID_W-1:0]     item_id,
  input  logic [pqs_pkg::PRI_W-1:0]    priority_req,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pqs_pkg::STATUS_W-1:0] status,
  output logic [pqs_pkg::ID_W-1:0]     out_id,
  output logic [pqs_pkg::PRI_W-1:0]    out_priority,
  output logic [pqs_pkg::COUNT_W-1:0]  entry_count,
  output logic                        is_empty
);
  import pqs_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              in_acc;
  logic              full;
  logic              empty;
  logic              is_ins;
  logic              is_deq;
  pqs_ctrl_t         ctrl;
  logic [ID_W-1:0]   c_id  [DEPTH];
  logic [PRI_W-1:0]  c_pri [DEPTH];
  logic [DEPTH-1:0]  c_occ;
  logic [DEPTH:0]    found;
  logic [STATUS_W-1:0] status_next;
  logic [CNT_W+COUNT_W-1:0] count_ext;

  // input handshake: a free or draining output register takes a new beat
  assign in_stall = out_valid && out_stall;
  assign in_acc   = in_valid && !in_stall;

  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);
  assign is_ins = (mode == MODE_APPEND) || (mode == MODE_INSERT);
  assign is_deq = (mode == MODE_DEQUEUE);

  // broadcast control for the row
  always_comb begin
    ctrl.ins    = in_acc && is_ins && !full;
    ctrl.by_pri = (mode == MODE_INSERT);
    ctrl.deq    = in_acc && is_deq && !empty;
    ctrl.id     = item_id;
    ctrl.pri    = priority_req;
  end

  // row of cells, slot 0 is the head
  assign found[0] = 1'b0;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [ID_W-1:0]  l_id;
    logic [PRI_W-1:0] l_pri;
    logic             l_occ;
    logic [ID_W-1:0]  r_id;
    logic [PRI_W-1:0] r_pri;
    logic             r_occ;

    if (k == 0) begin : g_left_edge
      assign l_id  = '0;
      assign l_pri = '0;
      assign l_occ = 1'b0;
    end else begin : g_left
      assign l_id  = c_id[k-1];
      assign l_pri = c_pri[k-1];
      assign l_occ = c_occ[k-1];
    end

    if (k == DEPTH - 1) begin : g_right_edge
      assign r_id  = '0;
      assign r_pri = '0;
      assign r_occ = 1'b0;
    end else begin : g_right
      assign r_id  = c_id[k+1];
      assign r_pri = c_pri[k+1];
      assign r_occ = c_occ[k+1];
    end

    pqs_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .found_in  (found[k]),
      .left_id   (l_id),
      .left_pri  (l_pri),
      .left_occ  (l_occ),
      .right_id  (r_id),
      .right_pri (r_pri),
      .right_occ (r_occ),
      .found_out (found[k+1]),
      .id        (c_id[k]),
      .pri       (c_pri[k]),
      .occ       (c_occ[k])
    );
  end

  // fill count and status
  always_comb begin
    count_next  = count;
    status_next = ST_OK;
    if (is_ins) begin
      if (full) begin
        status_next = ST_FULL;
      end else begin
        count_next = count + 1'b1;
      end
    end else if (is_deq) begin
      if (empty) begin
        status_next = ST_EMPTY;
      end else begin
        count_next = count - 1'b1;
      end
    end
  end

  assign count_ext = {{COUNT_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_acc) begin
      count <= count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      status      <= status_next;
      out_id      <= ctrl.deq ? c_id[0] : '0;
      out_priority <= ctrl.deq ? c_pri[0] : '0;
      entry_count <= count_ext[COUNT_W-1:0];
      is_empty    <= (count_next == '0);
    end
  end

  // checks
  `PQS_ASSERT(a_occ_matches_count, $countones(c_occ) == count, "occupancy differs from count")
  `PQS_ASSERT(a_count_bound, count <= CNT_W'(DEPTH), "count above depth")
  `PQS_ASSERT(a_deq_shrinks, in_acc && is_deq && !empty |=> count == $past(count) - 1'b1, "dequeue did not shrink count")
  `PQS_ASSERT(a_empty_zero, out_valid && status == ST_EMPTY |-> out_id == '0 && out_priority == '0, "empty dequeue returned data")

endmodule
